// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the quad screen overlap checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define QSOT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define QSOT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `QSOT_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/qsot_pkg.sv =====
// ----------------------------------------------------------------------------
// Quad screen overlap test package
// Payload types, register codes and width helpers shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package qsot_pkg;

  // Field widths.
  localparam int CoordW     = 16;
  localparam int ScreenW    = 14;
  localparam int DiffW      = CoordW + 1;
  localparam int CfgIdxW    = 2;
  localparam int NumCorners = 4;

  // Selectors for the horizontal and vertical reference positions.
  localparam int NumX    = 3;
  localparam int X_ZERO  = 0;
  localparam int X_WIDTH = 1;
  localparam int X_RAY   = 2;
  localparam int NumY     = 2;
  localparam int Y_ZERO   = 0;
  localparam int Y_HEIGHT = 1;

  // Register reset values.
  localparam logic [ScreenW-1:0] WidthRst  = ScreenW'(1920);
  localparam logic [ScreenW-1:0] HeightRst = ScreenW'(1080);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_CORNER = 2'd1,
    CAUSE_RAY    = 2'd2,
    CAUSE_EDGE   = 2'd3
  } cause_e;

  typedef struct packed {
    logic signed [CoordW-1:0] corner0_x;
    logic signed [CoordW-1:0] corner0_y;
    logic signed [CoordW-1:0] corner1_x;
    logic signed [CoordW-1:0] corner1_y;
    logic signed [CoordW-1:0] corner2_x;
    logic signed [CoordW-1:0] corner2_y;
    logic signed [CoordW-1:0] corner3_x;
    logic signed [CoordW-1:0] corner3_y;
  } quad_t;

  typedef struct packed {
    logic   overlaps;
    cause_e cause;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [ScreenW-1:0] value;
  } cfg_t;

  // Position of one quad corner against the screen bounds.
  typedef struct packed {
    logic in_screen;
    logic x_lt0;
    logic x_gtw;
    logic y_lt0;
    logic y_gt0;
    logic y_lth;
    logic y_gth;
  } pt_flags_t;

  // Width of a horizontal offset from a quad corner to 0, the width or the ray end.
  function automatic int xoff_width(input int ray_end);
    return $clog2(ray_end + (1 << (CoordW - 1)) + 1) + 1;
  endfunction

  // Width of an edge slope times a horizontal offset.
  function automatic int prod_width(input int ray_end);
    return DiffW + xoff_width(ray_end);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qsot_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsot_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qsot_prep.sv =====
// ----------------------------------------------------------------------------
// Quad screen overlap: operand preparation
// Forms edge slopes, offsets to the reference positions and corner flags.
// ----------------------------------------------------------------------------
`default_nettype none

module qsot_prep #(
  parameter int RAY_END_X = 100000
) (
  input  qsot_pkg::quad_t                                      quad_i,
  input  logic [qsot_pkg::ScreenW-1:0]                         width_i,
  input  logic [qsot_pkg::ScreenW-1:0]                         height_i,
  output logic signed [qsot_pkg::DiffW-1:0]                    dx_o   [qsot_pkg::NumCorners],
  output logic signed [qsot_pkg::DiffW-1:0]                    dy_o   [qsot_pkg::NumCorners],
  output logic signed [qsot_pkg::xoff_width(RAY_END_X)-1:0]
                      xoff_o [qsot_pkg::NumCorners][qsot_pkg::NumX],
  output logic signed [qsot_pkg::DiffW-1:0]
                      yoff_o [qsot_pkg::NumCorners][qsot_pkg::NumY],
  output qsot_pkg::pt_flags_t                                  flags_o [qsot_pkg::NumCorners]
);
  import qsot_pkg::*;

  localparam int XW = xoff_width(RAY_END_X);

  logic signed [CoordW-1:0] qx [NumCorners];
  logic signed [CoordW-1:0] qy [NumCorners];
  logic signed [DiffW-1:0]  wx;
  logic signed [DiffW-1:0]  hy;
  logic signed [XW-1:0]     xpt [NumX];
  logic signed [DiffW-1:0]  ypt [NumY];

  // Unpack the corners and the reference positions.
  always_comb begin
    qx[0] = quad_i.corner0_x;
    qy[0] = quad_i.corner0_y;
    qx[1] = quad_i.corner1_x;
    qy[1] = quad_i.corner1_y;
    qx[2] = quad_i.corner2_x;
    qy[2] = quad_i.corner2_y;
    qx[3] = quad_i.corner3_x;
    qy[3] = quad_i.corner3_y;
    wx = $signed({{(DiffW - ScreenW){1'b0}}, width_i});
    hy = $signed({{(DiffW - ScreenW){1'b0}}, height_i});
    xpt[X_ZERO]   = '0;
    xpt[X_WIDTH]  = $signed({{(XW - ScreenW){1'b0}}, width_i});
    xpt[X_RAY]    = XW'(RAY_END_X);
    ypt[Y_ZERO]   = '0;
    ypt[Y_HEIGHT] = hy;
  end

  for (genvar i = 0; i < NumCorners; i++) begin : g_edge
    localparam int N = (i + 1) % NumCorners;
    logic signed [DiffW-1:0] sx;
    logic signed [DiffW-1:0] sy;

    // Edge from corner i to the next corner; offsets are taken from its end.
    assign dx_o[i] = DiffW'(qx[N]) - DiffW'(qx[i]);
    assign dy_o[i] = DiffW'(qy[N]) - DiffW'(qy[i]);

    for (genvar k = 0; k < NumX; k++) begin : g_xoff
      assign xoff_o[i][k] = xpt[k] - XW'(qx[N]);
    end

    for (genvar m = 0; m < NumY; m++) begin : g_yoff
      assign yoff_o[i][m] = ypt[m] - DiffW'(qy[N]);
    end

    // Where corner i lies against the screen bounds.
    assign sx = DiffW'(qx[i]);
    assign sy = DiffW'(qy[i]);
    assign flags_o[i].x_lt0  = qx[i][CoordW-1];
    assign flags_o[i].x_gtw  = sx > wx;
    assign flags_o[i].y_lt0  = qy[i][CoordW-1];
    assign flags_o[i].y_gt0  = !qy[i][CoordW-1] && (qy[i] != '0);
    assign flags_o[i].y_lth  = sy < hy;
    assign flags_o[i].y_gth  = sy > hy;
    assign flags_o[i].in_screen = !qx[i][CoordW-1] && (sx < wx) &&
                                  !qy[i][CoordW-1] && (sy < hy);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qsot_mul.sv =====
// ----------------------------------------------------------------------------
// Quad screen overlap: orientation products
// Multiplies every edge slope with its offsets to the reference positions.
// ----------------------------------------------------------------------------
`default_nettype none

module qsot_mul #(
  parameter int RAY_END_X = 100000
) (
  input  logic signed [qsot_pkg::DiffW-1:0]                 dx_i   [qsot_pkg::NumCorners],
  input  logic signed [qsot_pkg::DiffW-1:0]                 dy_i   [qsot_pkg::NumCorners],
  input  logic signed [qsot_pkg::xoff_width(RAY_END_X)-1:0]
                      xoff_i [qsot_pkg::NumCorners][qsot_pkg::NumX],
  input  logic signed [qsot_pkg::DiffW-1:0]
                      yoff_i [qsot_pkg::NumCorners][qsot_pkg::NumY],
  output logic signed [qsot_pkg::prod_width(RAY_END_X)-1:0]
                      a_o    [qsot_pkg::NumCorners][qsot_pkg::NumX],
  output logic signed [2*qsot_pkg::DiffW-1:0]
                      b_o    [qsot_pkg::NumCorners][qsot_pkg::NumY]
);
  import qsot_pkg::*;

  localparam int AW = prod_width(RAY_END_X);
  localparam int BW = 2 * DiffW;

  // Exact signed products: slope_y * x offset and slope_x * y offset.
  for (genvar i = 0; i < NumCorners; i++) begin : g_edge
    for (genvar k = 0; k < NumX; k++) begin : g_a
      assign a_o[i][k] = AW'(dy_i[i] * xoff_i[i][k]);
    end
    for (genvar m = 0; m < NumY; m++) begin : g_b
      assign b_o[i][m] = BW'(dx_i[i] * yoff_i[i][m]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qsot_decide.sv =====
// ----------------------------------------------------------------------------
// Quad screen overlap: decision
// Turns the products into orientations, finds crossings and picks the cause.
// ----------------------------------------------------------------------------
`default_nettype none

module qsot_decide #(
  parameter int RAY_END_X = 100000
) (
  input  logic signed [qsot_pkg::prod_width(RAY_END_X)-1:0]
                      a_i     [qsot_pkg::NumCorners][qsot_pkg::NumX],
  input  logic signed [2*qsot_pkg::DiffW-1:0]
                      b_i     [qsot_pkg::NumCorners][qsot_pkg::NumY],
  input  qsot_pkg::pt_flags_t                    flags_i [qsot_pkg::NumCorners],
  input  logic [qsot_pkg::ScreenW-1:0]           width_i,
  input  logic [qsot_pkg::ScreenW-1:0]           height_i,
  output qsot_pkg::cause_e                       cause_o
);
  import qsot_pkg::*;

  localparam int AW = prod_width(RAY_END_X);
  localparam int PW = AW + 1;
  localparam int XW = xoff_width(RAY_END_X);

  // Reference points: the four screen corners, then the two ray ends.
  localparam int NumPts      = 6;
  localparam int PT_RAY_LOW  = 4;
  localparam int PT_RAY_HIGH = 5;

  localparam logic [XW-1:0] RayEnd = XW'(RAY_END_X);
  localparam logic          RayPos = RAY_END_X > 0;

  logic [NumCorners-1:0][NumPts-1:0]     cw;
  logic [NumCorners-1:0][NumCorners-1:0] hcw;
  logic [NumCorners-1:0][NumCorners-1:0] scw;
  logic [NumCorners-1:0][NumCorners-1:0] ray_hit;
  logic [NumCorners-1:0][NumCorners-1:0] edge_hit;
  logic [NumCorners-1:0]                 corner_in;
  logic                                  wide_pos;
  logic                                  wide_neg;
  logic                                  w_nz;
  logic                                  h_nz;

  // Sign of the ray length when the ray starts at the right screen border.
  assign wide_pos = RayEnd > XW'(width_i);
  assign wide_neg = RayEnd < XW'(width_i);
  assign w_nz     = width_i != '0;
  assign h_nz     = height_i != '0;

  // Clockwise test of every reference point against every quad edge.
  for (genvar i = 0; i < NumCorners; i++) begin : g_orient
    for (genvar p = 0; p < NumPts; p++) begin : g_pt
      localparam int XS = (p == 0 || p == 3) ? X_ZERO :
                          (p >= PT_RAY_LOW)  ? X_RAY  : X_WIDTH;
      localparam int YS = (p == 0 || p == 1 || p == PT_RAY_LOW) ? Y_ZERO : Y_HEIGHT;
      logic signed [PW-1:0] cross_v;
      assign cross_v    = PW'(a_i[i][XS]) - PW'(b_i[i][YS]);
      assign cw[i][p]   = !cross_v[PW-1] && (cross_v != '0);
    end
  end

  // Clockwise tests of the quad corners against the rays and screen edges.
  for (genvar j = 0; j < NumCorners; j++) begin : g_seg
    for (genvar c = 0; c < NumCorners; c++) begin : g_corner
      if (j == 0) begin : g_bottom
        assign hcw[j][c] = RayPos && flags_i[c].y_lt0;
        assign scw[j][c] = w_nz && flags_i[c].y_lt0;
      end else if (j == 1) begin : g_right
        assign hcw[j][c] = (wide_pos && flags_i[c].y_lt0) || (wide_neg && flags_i[c].y_gt0);
        assign scw[j][c] = h_nz && flags_i[c].x_gtw;
      end else if (j == 2) begin : g_top
        assign hcw[j][c] = (wide_pos && flags_i[c].y_lth) || (wide_neg && flags_i[c].y_gth);
        assign scw[j][c] = w_nz && flags_i[c].y_gth;
      end else begin : g_left
        assign hcw[j][c] = RayPos && flags_i[c].y_lth;
        assign scw[j][c] = h_nz && flags_i[c].x_lt0;
      end
    end
  end

  // Segment crossings: orientations must differ both ways round.
  for (genvar i = 0; i < NumCorners; i++) begin : g_cross
    localparam int N = (i + 1) % NumCorners;
    assign corner_in[i] = flags_i[i].in_screen;
    for (genvar j = 0; j < NumCorners; j++) begin : g_screen
      localparam int M  = (j + 1) % NumCorners;
      localparam int RE = (j < 2) ? PT_RAY_LOW : PT_RAY_HIGH;
      assign ray_hit[j][i]  = (cw[i][j] ^ cw[i][RE]) && (hcw[j][i] ^ hcw[j][N]);
      assign edge_hit[i][j] = (cw[i][j] ^ cw[i][M]) && (scw[j][i] ^ scw[j][N]);
    end
  end

  // The first test that succeeds names the cause.
  always_comb begin
    if (|corner_in) begin
      cause_o = CAUSE_CORNER;
    end else if (|ray_hit) begin
      cause_o = CAUSE_RAY;
    end else if (|edge_hit) begin
      cause_o = CAUSE_EDGE;
    end else begin
      cause_o = CAUSE_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/quad_screen_overlap_test.sv =====
// ----------------------------------------------------------------------------
// Quad screen overlap test: culls a projected quad against the screen.
// 2 stage regs (quad1_q, res_q); the product and compare path sets the cycle time.
// Throughput: one quad per cycle unless result_o stalls the output stage.
// Reset clears both stage valids; the screen size resets to 1920 x 1080.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_screen_overlap_test #(
  parameter int RAY_END_X = 100000
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  qsot_stream_if.sink   quad_i,
  qsot_stream_if.source result_o,
  qsot_stream_if.sink   cfg_i
);
  import qsot_pkg::*;

  localparam int XW = xoff_width(RAY_END_X);
  localparam int AW = prod_width(RAY_END_X);
  localparam int BW = 2 * DiffW;

  // Configuration registers.
  logic [ScreenW-1:0] width_q;
  logic [ScreenW-1:0] height_q;

  // Stage valids and advance enables.
  logic v1_q, out_valid_q;
  logic en1, en_out;

  // Input register and the combinational operands between the two stages.
  quad_t                   quad1_q;
  logic signed [DiffW-1:0] dx    [NumCorners];
  logic signed [DiffW-1:0] dy    [NumCorners];
  logic signed [XW-1:0]    xoff  [NumCorners][NumX];
  logic signed [DiffW-1:0] yoff  [NumCorners][NumY];
  pt_flags_t               flags [NumCorners];
  logic signed [AW-1:0]    prod_a [NumCorners][NumX];
  logic signed [BW-1:0]    prod_b [NumCorners][NumY];
  cause_e                  cause_d;
  result_t                 res_d;
  result_t                 res_q;

  // A stage moves on when it is empty or the stage after it moves on.
  assign en_out = !out_valid_q || result_o.ready;
  assign en1    = !v1_q || en_out;

  assign quad_i.ready   = en1;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = res_q;
  assign cfg_i.ready    = 1'b1;

  // Configuration writes; unknown register indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_SCREEN_WIDTH:  width_q  <= cfg_i.data.value;
        REG_SCREEN_HEIGHT: height_q <= cfg_i.data.value;
        default: begin
        end
      endcase
    end
  end

  // Stage valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= quad_i.valid;
      if (en_out) out_valid_q <= v1_q;
    end
  end

  // Operand preparation from the input register.
  qsot_prep #(
    .RAY_END_X(RAY_END_X)
  ) u_prep (
    .quad_i  (quad1_q),
    .width_i (width_q),
    .height_i(height_q),
    .dx_o    (dx),
    .dy_o    (dy),
    .xoff_o  (xoff),
    .yoff_o  (yoff),
    .flags_o (flags)
  );

  // Orientation products.
  qsot_mul #(
    .RAY_END_X(RAY_END_X)
  ) u_mul (
    .dx_i  (dx),
    .dy_i  (dy),
    .xoff_i(xoff),
    .yoff_i(yoff),
    .a_o   (prod_a),
    .b_o   (prod_b)
  );

  // Decision from the products and corner flags.
  qsot_decide #(
    .RAY_END_X(RAY_END_X)
  ) u_decide (
    .a_i     (prod_a),
    .b_i     (prod_b),
    .flags_i (flags),
    .width_i (width_q),
    .height_i(height_q),
    .cause_o (cause_d)
  );

  assign res_d.overlaps = cause_d != CAUSE_NONE;
  assign res_d.cause    = cause_d;

  // Stage payload registers, loaded only with a valid item.
  always_ff @(posedge clk_i) begin
    if (en1 && quad_i.valid) begin
      quad1_q <= quad_i.data;
    end
    if (en_out && v1_q) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qsot_checker.sv =====
// ----------------------------------------------------------------------------
// Quad screen overlap: port checker
// Watches the top level ports for result consistency and pipeline occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qsot_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input qsot_pkg::result_t out_data_i
);
  import qsot_pkg::*;

  // Two stage registers can hold at most two quads.
  localparam logic [1:0] MaxInFlight = 2'd2;

  logic       in_xfer;
  logic       out_xfer;
  logic       out_stall;
  logic       flag_ok;
  logic       pipe_full;
  logic       pipe_empty;
  logic [$bits(result_t):0] out_view;
  logic [1:0] inflight_q;
  logic [1:0] inflight_d;

  assign in_xfer    = in_valid_i && in_ready_i;
  assign out_xfer   = out_valid_i && out_ready_i;
  assign out_stall  = out_valid_i && !out_ready_i;
  assign flag_ok    = out_data_i.overlaps == (out_data_i.cause != CAUSE_NONE);
  assign pipe_full  = out_stall && (inflight_q == MaxInFlight);
  assign pipe_empty = inflight_q == '0;
  assign out_view   = {out_valid_i, out_data_i};

  // Count of quads taken in whose results are not yet transferred.
  always_comb begin
    case ({in_xfer, out_xfer})
      2'b10:   inflight_d = inflight_q + 2'd1;
      2'b01:   inflight_d = inflight_q - 2'd1;
      default: inflight_d = inflight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `QSOT_ASSERT(a_flag_cause, clk_i, rst_ni, out_valid_i |-> flag_ok, "flag and cause disagree")
  `QSOT_ASSERT(a_held, clk_i, rst_ni, out_stall |=> $stable(out_view), "stalled result changed")
  `QSOT_ASSERT(a_stall_full, clk_i, rst_ni, !in_ready_i |-> pipe_full, "input stalled with room")
  `QSOT_ASSERT_NEVER(a_depth_bound, clk_i, rst_ni, inflight_q > MaxInFlight, "depth exceeded")
  `QSOT_ASSERT_NEVER(a_no_spurious, clk_i, rst_ni, out_valid_i && pipe_empty, "spurious result")

endmodule

bind quad_screen_overlap_test qsot_checker u_qsot_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (quad_i.valid),
  .in_ready_i (quad_i.ready),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_data_i (result_o.data)
);

`default_nettype wire

// ===== dv/quad_screen_overlap_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad screen overlap test bench
// Streams projected quads through the culling block under several screen
// sizes, predicts each verdict with an exact 64-bit orientation model and
// compares every result transfer in order, with random gaps on both sides.
// ----------------------------------------------------------------------------

module quad_screen_overlap_test_tb;
  import qsot_pkg::*;

  localparam int RayEndX       = 100000;
  localparam int GapPct        = 23;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 8;

  // Indexes past the register list; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  qsot_stream_if #(.payload_t(quad_t))   quad_if ();
  qsot_stream_if #(.payload_t(result_t)) verdict_if ();
  qsot_stream_if #(.payload_t(cfg_t))    cfg_if ();

  quad_screen_overlap_test #(
    .RAY_END_X(RayEndX)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .quad_i  (quad_if),
    .result_o(verdict_if),
    .cfg_i   (cfg_if)
  );

  // Screen size as the block should currently see it.
  logic [ScreenW-1:0] scr_width  = WidthRst;
  logic [ScreenW-1:0] scr_height = HeightRst;

  quad_t       quad_backlog[$];
  result_t     verdict_q[$];
  int unsigned quads_queued   = 0;
  int unsigned verdicts_seen  = 0;
  int unsigned mismatch_count = 0;

  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;
  bit hold_off_armed  = 1'b0;
  int hold_cycles     = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Orientation of r against the directed line p->q; collinear is not clockwise.
  function automatic bit turns_cw(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    return v > 0;
  endfunction

  function automatic bit segments_cross(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy, longint dx, longint dy);
    bit o1, o2, o3, o4;
    o1 = turns_cw(ax, ay, bx, by, cx, cy);
    o2 = turns_cw(ax, ay, bx, by, dx, dy);
    o3 = turns_cw(cx, cy, dx, dy, ax, ay);
    o4 = turns_cw(cx, cy, dx, dy, bx, by);
    return (o1 != o2) && (o3 != o4);
  endfunction

  // Culling verdict for one quad against the current screen size.
  function automatic result_t cull_verdict(quad_t q);
    longint qx[4], qy[4], sx[4], sy[4];
    longint w, h;
    cause_e why;
    result_t r;
    int n, m;
    why = CAUSE_NONE;
    w = scr_width;
    h = scr_height;
    qx[0] = longint'($signed(q.corner0_x));
    qy[0] = longint'($signed(q.corner0_y));
    qx[1] = longint'($signed(q.corner1_x));
    qy[1] = longint'($signed(q.corner1_y));
    qx[2] = longint'($signed(q.corner2_x));
    qy[2] = longint'($signed(q.corner2_y));
    qx[3] = longint'($signed(q.corner3_x));
    qy[3] = longint'($signed(q.corner3_y));
    sx[0] = 0; sy[0] = 0;
    sx[1] = w; sy[1] = 0;
    sx[2] = w; sy[2] = h;
    sx[3] = 0; sy[3] = h;

    // A quad corner inside the half-open screen rectangle.
    for (int i = 0; i < 4; i++) begin
      if (why == CAUSE_NONE && qx[i] >= 0 && qx[i] < w && qy[i] >= 0 && qy[i] < h) begin
        why = CAUSE_CORNER;
      end
    end

    // Any quad edge hit by a ray from a screen corner; a single hit is enough.
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        n = (i + 1) % 4;
        if (why == CAUSE_NONE &&
            segments_cross(qx[i], qy[i], qx[n], qy[n], sx[j], sy[j], RayEndX, sy[j])) begin
          why = CAUSE_RAY;
        end
      end
    end

    // Any quad edge crossing any screen edge.
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        n = (i + 1) % 4;
        m = (j + 1) % 4;
        if (why == CAUSE_NONE &&
            segments_cross(qx[i], qy[i], qx[n], qy[n], sx[j], sy[j], sx[m], sy[m])) begin
          why = CAUSE_EDGE;
        end
      end
    end

    r.overlaps = (why != CAUSE_NONE);
    r.cause    = why;
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] clamp_coord(int v);
    if (v < -32768) begin
      v = -32768;
    end else if (v > 32767) begin
      v = 32767;
    end
    return v[CoordW-1:0];
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic quad_t make_quad(int x0, int y0, int x1, int y1,
                                      int x2, int y2, int x3, int y3);
    quad_t q;
    q.corner0_x = clamp_coord(x0);
    q.corner0_y = clamp_coord(y0);
    q.corner1_x = clamp_coord(x1);
    q.corner1_y = clamp_coord(y1);
    q.corner2_x = clamp_coord(x2);
    q.corner2_y = clamp_coord(y2);
    q.corner3_x = clamp_coord(x3);
    q.corner3_y = clamp_coord(y3);
    return q;
  endfunction

  // Random quad: mostly shapes placed around the screen, some raw noise.
  function automatic quad_t random_quad(int w, int h);
    int xs[4], ys[4];
    int span, sel, rot, quadrant;
    span = (w > h) ? w : h;
    if (span < 4) begin
      span = 4;
    end
    sel = $urandom_range(0, 99);
    rot = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      if (sel < 25) begin
        xs[k] = int'($urandom_range(0, 65535)) - 32768;
        ys[k] = int'($urandom_range(0, 65535)) - 32768;
      end else if (sel < 65) begin
        xs[k] = pick(-span / 2, span + span / 2);
        ys[k] = pick(-span / 2, span + span / 2);
      end else if (sel < 85) begin
        // One corner per outer quadrant, so the quad tends to wrap the screen.
        quadrant = (k + rot) % 4;
        xs[k] = (quadrant == 0 || quadrant == 3) ? pick(-3 * span, -1) : pick(w, w + 3 * span);
        ys[k] = (quadrant == 0 || quadrant == 1) ? pick(-3 * span, -1) : pick(h, h + 3 * span);
      end else begin
        // Hug the screen border lines to reach collinear and touching cases.
        xs[k] = ($urandom_range(0, 1) ? w : 0) + pick(-3, 3);
        ys[k] = ($urandom_range(0, 1) ? h : 0) + pick(-3, 3);
      end
    end
    return make_quad(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3]);
  endfunction

  task automatic queue_quad(quad_t q);
    quad_backlog.insert(quad_backlog.size(), q);
    quads_queued++;
  endtask

  task automatic queue_random(int count, int w, int h);
    for (int k = 0; k < count; k++) begin
      queue_quad(random_quad(w, h));
    end
  endtask

  // Quads sitting on the rectangle bounds of the given screen size.
  task automatic queue_border_probes(int w, int h);
    queue_quad(make_quad(w - 1, h - 1, w - 1, h - 1, w - 1, h - 1, w - 1, h - 1));
    queue_quad(make_quad(w, h, w, h, w, h, w, h));
    queue_quad(make_quad(0, 0, -9, 0, -9, -9, 0, -9));
    queue_quad(make_quad(-1, -1, w + 1, -1, w + 1, h + 1, -1, h + 1));
  endtask

  // Wait until every queued quad has produced its checked result.
  task automatic settle();
    while (verdicts_seen != quads_queued) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ScreenW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do begin
      @(posedge clk_i);
    end while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_screen(int w, int h);
    write_reg(REG_SCREEN_WIDTH, w[ScreenW-1:0]);
    write_reg(REG_SCREEN_HEIGHT, h[ScreenW-1:0]);
  endtask

  task automatic run_phase(int w, int h, int count);
    settle();
    set_screen(w, h);
    queue_border_probes(w, h);
    queue_random(count, w, h);
  endtask

  // Quad driver: offers the next pending quad once the previous one is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quad_if.valid <= 1'b0;
    end else if (!quad_if.valid || quad_if.ready) begin
      if (quad_backlog.size() != 0 &&
          (sender_steady || $urandom_range(0, 99) >= GapPct)) begin
        quad_if.valid <= 1'b1;
        quad_if.data  <= quad_backlog.pop_front();
      end else begin
        quad_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off when armed.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      verdict_if.ready <= 1'b0;
    end else if (hold_off_armed && hold_cycles < HoldOffCycles) begin
      verdict_if.ready <= 1'b0;
      hold_cycles      <= hold_cycles + 1;
    end else begin
      verdict_if.ready <= receiver_steady || ($urandom_range(0, 99) >= GapPct);
    end
  end

  // Monitor: tracks register writes, predicts on quad transfers and checks results.
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          REG_SCREEN_WIDTH: begin
            scr_width = cfg_if.data.value;
          end
          REG_SCREEN_HEIGHT: begin
            scr_height = cfg_if.data.value;
          end
          default: begin
          end
        endcase
      end
      if (quad_if.valid && quad_if.ready) begin
        verdict_q.insert(verdict_q.size(), cull_verdict(quad_if.data));
      end
      if (verdict_if.valid && verdict_if.ready) begin
        got = verdict_if.data;
        if (verdict_q.size() == 0) begin
          $error("result transfer with no quad pending: overlaps %0b, cause %0d",
                 got.overlaps, got.cause);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (got.overlaps !== want.overlaps) begin
            $error("overlaps: expected %0b, got %0b", want.overlaps, got.overlaps);
            mismatch_count++;
          end
          if (got.cause !== want.cause) begin
            $error("cause: expected %0d, got %0d", want.cause, got.cause);
            mismatch_count++;
          end
          verdicts_seen++;
        end
      end
    end
  end

  // Stimulus sequence: reset, directed quads, then phases over screen sizes.
  initial begin
    int w, h;
    quad_if.valid    = 1'b0;
    quad_if.data     = '0;
    verdict_if.ready = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed quads against the reset screen size.
    queue_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
    queue_quad(make_quad(1919, 1079, -5000, -5000, -5000, 5000, 5000, -5000));
    queue_quad(make_quad(1920, 1080, 1920, 1080, 1920, 1080, 1920, 1080));
    queue_quad(make_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    queue_quad(make_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    queue_quad(make_quad(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
    queue_quad(make_quad(-100, -100, 3000, -100, 3000, 2000, -100, 2000));
    queue_quad(make_quad(-100, 500, 3000, 500, 3000, 501, -100, 501));
    queue_quad(make_quad(-50, 0, 3000, 0, 3000, -10, -50, -10));
    queue_quad(make_quad(2500, -10, 2600, -10, 2600, 10, 2500, 10));
    queue_quad(make_quad(-5, -5, 5, -5, 5, -1, -5, -1));
    queue_quad(make_quad(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846));
    queue_quad(make_quad(500, -100, 501, -100, 501, 5000, 500, 5000));
    queue_quad(make_quad(-1, -1, -1, -1, -1, -1, -1, -1));
    queue_quad(make_quad(1920, 0, 1920, 0, 0, 1080, 0, 1080));
    queue_quad(make_quad(-100, -100, 3000, 2000, 3000, -100, -100, 2000));
    queue_quad(make_quad(-40, 1080, 40, 1080, 40, 1100, -40, 1100));
    queue_random(150, 1920, 1080);

    // Smallest and largest nominal sizes, then sizes outside the nominal range.
    run_phase(1, 1, 70);
    run_phase(8192, 8192, 70);
    run_phase(0, 16383, 60);

    // No idling on either side; stray register indexes must leave the size alone.
    settle();
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    set_screen(16383, 0);
    write_reg(RegSpareLo, 14'd77);
    write_reg(RegSpareHi, 14'h3FFF);
    queue_border_probes(16383, 0);
    queue_random(80, 16383, 0);
    settle();
    receiver_steady = 1'b0;

    // Long receiver hold-off while quads keep coming, so the block backs up.
    set_screen(640, 480);
    hold_off_armed = 1'b1;
    queue_random(100, 640, 480);
    settle();
    sender_steady = 1'b0;

    // A few random sizes.
    for (int k = 0; k < 3; k++) begin
      w = pick(1, 8192);
      h = pick(1, 8192);
      run_phase(w, h, 50);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
